FILE: design/hst_pkg.sv
// Shared types, constants and width helpers for the heater sensor thermostat.
// Used by hst_ctrl, hst_datapath, the top level and the checker.
// No dependencies.
package hst_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_STEPS_DEF = 205;

    // Field widths
    localparam int MV_W      = 13;
    localparam int TARGET_W  = 8;
    localparam int TEMP_W    = 10;
    localparam int HYST_W    = 6;
    localparam int OFFS_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_OFFSET = 1'b1;

    localparam logic [HYST_W-1:0]        HYST_RESET = 6'd3;
    localparam logic signed [OFFS_W-1:0] OFFS_RESET = 7'sd0;

    // Sensor conversion constants
    localparam int MV_LIMIT      = 5000;
    localparam int BASE_TEMP     = 50;
    localparam int VDIV_NUM      = 2550000;  // 2550 V*mV scale
    localparam int R_SERIES      = 510;
    localparam int RATIO_SCALE   = 10000;
    localparam int DIVISOR_SCALE = 7284992;  // 8 * 91.0624 scaled

    // One temperature step: u * 625 / 628 going up, u * 625 / 622 going down
    localparam int STEP_MUL      = 625;
    localparam int STEP_DIV_UP   = 628;
    localparam int STEP_DIV_DOWN = 622;

    // Datapath widths
    localparam int DIFF_W     = 22;  // 2550000 - 510*mv
    localparam int NUM_W      = 35;  // diff * 10000
    localparam int DIVR_W     = 36;  // mv * 7284992
    localparam int U_INT_W    = 12;  // integer bits of the ratio u
    localparam int STEP_MUL_W = 10;  // growth from the * 625
    localparam int DIGIT_W    = 4;   // radix-16 constant divider
    localparam int DREM_W     = 10;  // remainder below 628
    localparam int PART_W     = DREM_W + DIGIT_W;

    function automatic int dvd_width(input int frac);
        return NUM_W + frac;
    endfunction

    function automatic int u_width(input int frac);
        return U_INT_W + frac;
    endfunction

    function automatic int digit_count(input int frac);
        return (U_INT_W + frac + STEP_MUL_W + DIGIT_W - 1) / DIGIT_W;
    endfunction

    // Input and result words
    typedef struct packed {
        logic [MV_W-1:0]     sample_mv;
        logic [TARGET_W-1:0] target_temp;
        logic                heater_enabled;
    } sample_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     heat_on;
        logic                     sensor_error;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch the input word
        logic prep_div;     // diff and divisor
        logic prep_num;     // dividend, clear remainder
        logic div_step;     // one restoring divide bit
        logic step_init;    // take u, pick direction, clear step count
        logic step_mul;     // x = u * 625
        logic dig_step;     // one radix-16 digit of x / D
        logic step_update;  // u = quotient, count the step
        logic finish;       // temperature, heater decision, result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sensor_err;
        logic more;
    } status_t;

endpackage

FILE: design/hst_ctrl.sv
// Sequencer for the heater sensor thermostat: state machine, one counter
// and the result valid flag. Depends on hst_pkg for cmd_t and status_t.
module hst_ctrl #(
    parameter int FRAC_BITS = hst_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  hst_pkg::status_t status,
    output hst_pkg::cmd_t    cmd
);

    localparam int DVD_W    = hst_pkg::dvd_width(FRAC_BITS);
    localparam int N_DIGITS = hst_pkg::digit_count(FRAC_BITS);
    localparam int CNT_W    = $clog2(DVD_W);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP1 = 4'd1;
    localparam logic [3:0] ST_PREP2 = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_INIT = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_DIG  = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_TEST = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP1;
                end
            end
            ST_PREP1:
            begin
                if (status.sensor_err)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.prep_div = 1'b1;
                    state_next   = ST_PREP2;
                end
            end
            ST_PREP2:
            begin
                cmd.prep_num = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.step_init = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.step_mul = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIG;
            end
            ST_DIG:
            begin
                cmd.dig_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_DIGITS - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.step_update = 1'b1;
                state_next      = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = status.more ? ST_MUL : ST_FIN;
            end
            ST_FIN:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || result_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/hst_datapath.sv
// Datapath of the heater sensor thermostat: restoring divider for the
// resistance ratio, radix-16 constant divider for the temperature steps,
// configuration registers, heater state and result register. Uses hst_pkg.
module hst_datapath #(
    parameter int FRAC_BITS = hst_pkg::FRAC_BITS_DEF,
    parameter int MAX_STEPS = hst_pkg::MAX_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hst_pkg::sample_t                sample,
    output hst_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [hst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hst_pkg::CFG_W-1:0]       cfg_data,
    input  hst_pkg::cmd_t                   cmd,
    output hst_pkg::status_t                status
);

    localparam int DVD_W  = hst_pkg::dvd_width(FRAC_BITS);
    localparam int U_W    = hst_pkg::u_width(FRAC_BITS);
    localparam int X_W    = hst_pkg::digit_count(FRAC_BITS) * hst_pkg::DIGIT_W;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int DOWN_CAP = (MAX_STEPS < hst_pkg::BASE_TEMP) ? MAX_STEPS
                                                                : hst_pkg::BASE_TEMP;
    localparam int TW     = hst_pkg::TEMP_W;
    localparam int PW     = hst_pkg::PART_W;
    localparam int DW     = hst_pkg::DIGIT_W;

    localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_BITS;

    // Input word
    logic [hst_pkg::MV_W-1:0]     mv_reg;
    logic [hst_pkg::TARGET_W-1:0] target_reg;
    logic                         en_reg;

    // Ratio divider
    logic [hst_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic [hst_pkg::DIVR_W-1:0] divr_reg, divr_next;
    logic [hst_pkg::DIVR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]           dvd_reg, dvd_next;

    // Step loop
    logic [U_W-1:0]           u_reg, u_next;
    logic                     up_reg, up_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic [X_W-1:0]           x_reg, x_next;
    logic [hst_pkg::DREM_W-1:0] drem_reg, drem_next;
    logic [U_W-1:0]           q_reg, q_next;

    // Configuration and heater state
    logic [hst_pkg::HYST_W-1:0]        hyst_reg;
    logic signed [hst_pkg::OFFS_W-1:0] offs_reg;
    logic                              heater_reg, heater_next;
    hst_pkg::result_t                  result_reg, result_next;

    logic                       err;
    logic [hst_pkg::NUM_W-1:0]  num;
    logic [hst_pkg::DIVR_W:0]   trial;
    logic [hst_pkg::DIVR_W:0]   trial_diff;
    logic [PW-1:0]              part;
    logic [PW-1:0]              dconst;
    logic [DW-1:0]              digit;
    logic signed [TW-1:0]       temp_base;
    logic signed [TW-1:0]       temp_corr;
    logic signed [TW-1:0]       target_s;
    logic signed [TW-1:0]       on_thresh;

    assign err = (mv_reg == '0) || (mv_reg >= hst_pkg::MV_W'(hst_pkg::MV_LIMIT));

    assign status.sensor_err = err;
    assign status.more = up_reg
        ? ((u_reg > U_ONE) && (steps_reg < STEP_W'(MAX_STEPS)))
        : ((u_reg < U_ONE) && (steps_reg < STEP_W'(DOWN_CAP)));

    assign result = result_reg;

    // Restoring divide: one quotient bit per cycle
    always_comb
    begin
        num        = hst_pkg::NUM_W'(diff_reg) * hst_pkg::NUM_W'(hst_pkg::RATIO_SCALE);
        trial      = {rem_reg, dvd_reg[DVD_W-1]};
        trial_diff = trial - {1'b0, divr_reg};

        diff_next = diff_reg;
        divr_next = divr_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;

        if (cmd.prep_div)
        begin
            diff_next = hst_pkg::DIFF_W'(hst_pkg::VDIV_NUM)
                      - hst_pkg::DIFF_W'(mv_reg) * hst_pkg::DIFF_W'(hst_pkg::R_SERIES);
            divr_next = hst_pkg::DIVR_W'(mv_reg)
                      * hst_pkg::DIVR_W'(hst_pkg::DIVISOR_SCALE);
        end
        if (cmd.prep_num)
        begin
            dvd_next = DVD_W'(num) << FRAC_BITS;
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            if (!trial_diff[hst_pkg::DIVR_W])
            begin
                rem_next = trial_diff[hst_pkg::DIVR_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[hst_pkg::DIVR_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    // Step loop: x = u * 625, then x / 628 (or 622) one hex digit a cycle
    always_comb
    begin
        dconst = up_reg ? PW'(hst_pkg::STEP_DIV_UP) : PW'(hst_pkg::STEP_DIV_DOWN);
        part   = {drem_reg, x_reg[X_W-1 -: DW]};
        digit  = '0;
        for (int k = 1; k < (1 << DW); k++)
        begin
            if (part >= (up_reg ? PW'(k * hst_pkg::STEP_DIV_UP)
                                : PW'(k * hst_pkg::STEP_DIV_DOWN)))
            begin
                digit = DW'(k);
            end
        end

        u_next     = u_reg;
        up_next    = up_reg;
        steps_next = steps_reg;
        x_next     = x_reg;
        drem_next  = drem_reg;
        q_next     = q_reg;

        if (cmd.step_init)
        begin
            u_next     = dvd_reg[U_W-1:0];
            up_next    = (dvd_reg[U_W-1:0] > U_ONE);
            steps_next = '0;
        end
        if (cmd.step_mul)
        begin
            x_next    = X_W'(u_reg) * X_W'(hst_pkg::STEP_MUL);
            drem_next = '0;
            q_next    = '0;
        end
        if (cmd.dig_step)
        begin
            x_next    = x_reg << DW;
            drem_next = hst_pkg::DREM_W'(part - PW'(digit) * dconst);
            q_next    = {q_reg[U_W-DW-1:0], digit};
        end
        if (cmd.step_update)
        begin
            u_next     = q_reg;
            steps_next = steps_reg + 1'b1;
        end
    end

    // Temperature and hysteresis switch
    always_comb
    begin
        temp_base = up_reg ? (TW'(hst_pkg::BASE_TEMP) + TW'(steps_reg))
                           : (TW'(hst_pkg::BASE_TEMP) - TW'(steps_reg));
        temp_corr = temp_base - TW'(offs_reg);
        target_s  = signed'(TW'(target_reg));
        on_thresh = target_s - signed'(TW'(hyst_reg));

        heater_next = heater_reg;
        result_next = result_reg;

        if (cmd.finish)
        begin
            if (err || !en_reg || (temp_corr >= target_s))
            begin
                heater_next = 1'b0;
            end
            else if (temp_corr <= on_thresh)
            begin
                heater_next = 1'b1;
            end
            result_next.temperature  = err ? '0 : temp_corr;
            result_next.heat_on      = heater_next;
            result_next.sensor_error = err;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mv_reg     <= sample.sample_mv;
            target_reg <= sample.target_temp;
            en_reg     <= sample.heater_enabled;
        end
        diff_reg   <= diff_next;
        divr_reg   <= divr_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        u_reg      <= u_next;
        up_reg     <= up_next;
        steps_reg  <= steps_next;
        x_reg      <= x_next;
        drem_reg   <= drem_next;
        q_reg      <= q_next;
        result_reg <= result_next;
    end

    // Configuration registers and heater state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg   <= hst_pkg::HYST_RESET;
            offs_reg   <= hst_pkg::OFFS_RESET;
            heater_reg <= 1'b0;
        end
        else
        begin
            heater_reg <= heater_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    hst_pkg::REG_HYSTERESIS:  hyst_reg <= cfg_data[hst_pkg::HYST_W-1:0];
                    hst_pkg::REG_CORR_OFFSET: offs_reg <= signed'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: design/heater_sensor_thermostat.sv
// Heater sensor thermostat: voltage-to-temperature conversion and a
// hysteresis heater switch. Top level; uses hst_pkg, hst_ctrl, hst_datapath.
//
// Usage:
//   sample channel (sample_valid/sample_ready, sample): one word per sensor
//   reading: voltage in mV, target temperature, enable flag.
//   result channel (result_valid/result_ready, result): one word per sample:
//   corrected temperature, heater drive, sensor error flag.
//   cfg_write/cfg_index/cfg_data: register 0 hysteresis, 1 correction offset;
//   write only while no sample is in flight.
// Flow: one sample at a time. A faulty sample (0 mV or >= 5000 mV) skips
//   the divide and the step loop and goes straight to the result. Otherwise
//   the ratio divide runs one bit per cycle, then the temperature is
//   stepped (1 to MAX_STEPS steps; at most 50 down), each step a multiply
//   by 625 and a radix-16 divide of (22 + FRAC_BITS) / 4 digits, rounded up.
// Reset: heater off, hysteresis 3, offset 0, no result pending.
// Stall: the result register holds its word while result_ready is low; the
//   next sample is still taken and computed, then waits for the register.
module heater_sensor_thermostat #(
    parameter int FRAC_BITS = hst_pkg::FRAC_BITS_DEF,
    parameter int MAX_STEPS = hst_pkg::MAX_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  hst_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output hst_pkg::result_t              result,
    input  logic                          cfg_write,
    input  logic [hst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hst_pkg::CFG_W-1:0]     cfg_data
);

    hst_pkg::cmd_t    cmd;
    hst_pkg::status_t status;

    hst_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    hst_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: design/hst_checker.sv
// Port-level checks for the heater sensor thermostat, bound to the top level.
// Depends on hst_pkg and heater_sensor_thermostat.
module hst_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input hst_pkg::result_t result
);

    // stalled result word stays up and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word dropped or changed while stalled");

    // one sample at a time: busy right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while previous one in flight");

    // a faulty sensor never drives the heater
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sensor_error |-> !result.heat_on)
        else $error("heater on with sensor error");

    // faulty sample reports zero temperature
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sensor_error |-> result.temperature == '0)
        else $error("nonzero temperature with sensor error");

endmodule

bind heater_sensor_thermostat hst_checker u_hst_checker (.*);
